FILE: src/pssw_pkg.sv
// ----------------------------------------------------------------------------
// pssw_pkg: shared types and constants for the scored worker selector
// Widths, policy codes, queue entry and back end state types.
// ----------------------------------------------------------------------------
package pssw_pkg;

   localparam int MAX_WORKERS = 256;
   localparam int POS_WIDTH   = $clog2(MAX_WORKERS);
   localparam int INDEX_WIDTH = 8;

   localparam int LOAD_WIDTH  = 15;
   localparam int COUNT_WIDTH = 8;
   localparam int PRIO_WIDTH  = 8;
   localparam int TIME_WIDTH  = 32;

   // scores are signed with 8 fraction bits
   localparam int SCORE_WIDTH = 42;
   localparam int FRAC_BITS   = 8;
   localparam int MAG_WIDTH   = TIME_WIDTH + FRAC_BITS;
   localparam int DIV_WIDTH   = COUNT_WIDTH + 1;
   localparam int STEP_WIDTH  = $clog2(MAG_WIDTH);

   localparam logic signed [SCORE_WIDTH-1:0] FULL_SCALE = SCORE_WIDTH'(25600);
   localparam logic signed [SCORE_WIDTH-1:0] MINUS_ONE  = -SCORE_WIDTH'(256);

   // priority divide by ten as multiply by ceil(2^27 / 10) and shift,
   // exact for magnitudes below 2^26
   localparam int PRIO_MAG_WIDTH   = 23;
   localparam int RECIP_WIDTH      = 24;
   localparam int RECIP_SHIFT      = 27;
   localparam int RECIP_PROD_WIDTH = PRIO_MAG_WIDTH + RECIP_WIDTH;
   localparam logic [RECIP_WIDTH-1:0] PRIO_RECIP = RECIP_WIDTH'(13421773);

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      POLICY_LOAD,
      POLICY_ROUND_ROBIN,
      POLICY_PRIORITY,
      POLICY_DEADLINE
   } pssw_policy_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_EVAL
   } pssw_back_state_type;

   typedef struct packed {
      logic                          available;
      logic                          last;
      logic [POS_WIDTH-1:0]          position;
      logic                          use_div;
      logic                          use_recip;
      logic                          negative;
      logic [MAG_WIDTH-1:0]          magnitude;
      logic [DIV_WIDTH-1:0]          divisor;
      logic signed [SCORE_WIDTH-1:0] direct;
   } pssw_entry_type;

endpackage

FILE: src/pssw_if.sv
// ----------------------------------------------------------------------------
// pssw_req_if / pssw_rsp_if: request and result channels
// Valid/ready channels carrying worker records and selection results.
// ----------------------------------------------------------------------------
interface pssw_req_if;
   logic        valid;
   logic        ready;
   logic        available;
   logic [14:0] cpu_load;
   logic [14:0] mem_load;
   logic [7:0]  active_count;
   logic [7:0]  task_priority;
   logic [31:0] task_deadline;
   logic [31:0] time_now;
   logic        last;

   modport source (output valid, available, cpu_load, mem_load, active_count,
                   task_priority, task_deadline, time_now, last, input ready);
   modport sink (input valid, available, cpu_load, mem_load, active_count,
                 task_priority, task_deadline, time_now, last, output ready);
endinterface

interface pssw_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [7:0] worker_index;

   modport source (output valid, found, worker_index, input ready);
   modport sink (input valid, found, worker_index, output ready);
endinterface

FILE: src/pssw_front.sv
// ----------------------------------------------------------------------------
// pssw_front: request intake and scoring setup
// Numbers each worker record and prepares its score or divider operands.
// ----------------------------------------------------------------------------
module pssw_front
   import pssw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   pssw_req_if.sink        req_ch,
   input  pssw_policy_type policy,
   input  logic            q_full,
   output logic            q_push,
   output pssw_entry_type  q_entry
);

   logic [POS_WIDTH-1:0]          pos_ff;
   logic [POS_WIDTH-1:0]          pos_in;
   logic signed [SCORE_WIDTH-1:0] cpu_s;
   logic signed [SCORE_WIDTH-1:0] mem_s;
   logic signed [SCORE_WIDTH-1:0] act_s;
   logic signed [16:0]            head_room;
   logic signed [8:0]             prio_s;
   logic signed [25:0]            prod;
   logic [25:0]                   prod_abs;
   logic signed [TIME_WIDTH:0]    slack;
   logic [TIME_WIDTH:0]           slack_abs;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   assign cpu_s = $signed({{(SCORE_WIDTH-LOAD_WIDTH){1'b0}}, req_ch.cpu_load});
   assign mem_s = $signed({{(SCORE_WIDTH-LOAD_WIDTH){1'b0}}, req_ch.mem_load});
   assign act_s = $signed({{(SCORE_WIDTH-COUNT_WIDTH){1'b0}}, req_ch.active_count});

   assign head_room = 17'sd25600 - $signed({2'b00, req_ch.cpu_load});
   assign prio_s    = $signed({1'b0, req_ch.task_priority});
   assign prod      = 26'(head_room) * 26'(prio_s);
   assign prod_abs  = prod[25] ? 26'(-prod) : 26'(prod);

   assign slack     = $signed({1'b0, req_ch.task_deadline}) - $signed({1'b0, req_ch.time_now});
   assign slack_abs = slack[TIME_WIDTH] ? (TIME_WIDTH+1)'(-slack) : (TIME_WIDTH+1)'(slack);

   always_comb begin
      q_entry.available = req_ch.available;
      q_entry.last      = req_ch.last;
      q_entry.position  = pos_ff;
      q_entry.use_div   = 1'b0;
      q_entry.use_recip = 1'b0;
      q_entry.negative  = 1'b0;
      q_entry.magnitude = '0;
      q_entry.divisor   = '0;
      q_entry.direct    = '0;
      case (policy)
         POLICY_LOAD: begin
            q_entry.direct = (FULL_SCALE - cpu_s) + (FULL_SCALE - mem_s)
                             - ((act_s <<< 11) + (act_s <<< 9));
         end
         POLICY_ROUND_ROBIN: begin
            q_entry.direct = FULL_SCALE - (act_s <<< FRAC_BITS);
         end
         POLICY_PRIORITY: begin
            q_entry.use_div   = 1'b1;
            q_entry.use_recip = 1'b1;
            q_entry.negative  = prod[25];
            q_entry.magnitude = MAG_WIDTH'(prod_abs);
         end
         POLICY_DEADLINE: begin
            q_entry.use_div   = 1'b1;
            q_entry.negative  = slack[TIME_WIDTH];
            q_entry.magnitude = {slack_abs[TIME_WIDTH-1:0], {FRAC_BITS{1'b0}}};
            q_entry.divisor   = {1'b0, req_ch.active_count} + DIV_WIDTH'(1);
         end
         default: begin
            q_entry.direct = '0;
         end
      endcase
   end

   // position restarts after the record marked last
   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         pos_in = req_ch.last ? '0 : pos_ff + POS_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: src/pssw_queue.sv
// ----------------------------------------------------------------------------
// pssw_queue: two-entry queue between front and back
// Holds prepared requests so intake and scoring stall independently.
// ----------------------------------------------------------------------------
module pssw_queue
   import pssw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pssw_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           pop_valid,
   output pssw_entry_type pop_entry
);

   pssw_entry_type slot_ff [2];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;
   logic           do_pop;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/pssw_back.sv
// ----------------------------------------------------------------------------
// pssw_back: scoring, best tracking and result output
// Runs a bit-serial divider for the deadline policy and a reciprocal multiply
// for the priority scale, keeps the best score and drives the registered
// result channel.
// ----------------------------------------------------------------------------
module pssw_back
   import pssw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  pssw_entry_type q_entry,
   output logic           q_pop,
   pssw_rsp_if.source     rsp_ch
);

   pssw_back_state_type           state_ff;
   pssw_back_state_type           state_in;
   pssw_entry_type                cur_ff;
   pssw_entry_type                cur_in;
   logic [MAG_WIDTH-1:0]          quot_ff;
   logic [MAG_WIDTH-1:0]          quot_in;
   logic [DIV_WIDTH-1:0]          rem_ff;
   logic [DIV_WIDTH-1:0]          rem_in;
   logic [STEP_WIDTH-1:0]         step_ff;
   logic [STEP_WIDTH-1:0]         step_in;
   logic signed [SCORE_WIDTH-1:0] best_score_ff;
   logic signed [SCORE_WIDTH-1:0] best_score_in;
   logic [POS_WIDTH-1:0]          best_pos_ff;
   logic [POS_WIDTH-1:0]          best_pos_in;
   logic                          have_best_ff;
   logic                          have_best_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_found_ff;
   logic                          rsp_found_in;
   logic [INDEX_WIDTH-1:0]        rsp_index_ff;
   logic [INDEX_WIDTH-1:0]        rsp_index_in;

   logic [DIV_WIDTH:0]            trial;
   logic                          trial_ok;
   logic [RECIP_PROD_WIDTH-1:0]   recip_prod;
   logic [MAG_WIDTH-1:0]          recip_quot;
   logic signed [SCORE_WIDTH-1:0] quot_s;
   logic signed [SCORE_WIDTH-1:0] score;
   logic                          win;
   logic                          new_have;
   logic [POS_WIDTH-1:0]          new_pos;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.worker_index = rsp_index_ff;

   // restoring division, one quotient bit per cycle
   assign trial    = {rem_ff, quot_ff[MAG_WIDTH-1]};
   assign trial_ok = trial >= {1'b0, cur_ff.divisor};

   assign recip_prod = {{RECIP_WIDTH{1'b0}}, q_entry.magnitude[PRIO_MAG_WIDTH-1:0]}
                     * {{PRIO_MAG_WIDTH{1'b0}}, PRIO_RECIP};
   assign recip_quot = {{(MAG_WIDTH-RECIP_PROD_WIDTH+RECIP_SHIFT){1'b0}},
                        recip_prod[RECIP_PROD_WIDTH-1:RECIP_SHIFT]};

   assign quot_s   = $signed({{(SCORE_WIDTH-MAG_WIDTH){1'b0}}, quot_ff});
   assign score    = !cur_ff.use_div ? cur_ff.direct
                   : (cur_ff.negative ? -quot_s : quot_s);
   assign win      = cur_ff.available && (score > best_score_ff);
   assign new_have = have_best_ff || win;
   assign new_pos  = win ? cur_ff.position : best_pos_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      best_score_in = best_score_ff;
      best_pos_in   = best_pos_ff;
      have_best_in  = have_best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      q_pop         = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            q_pop = 1'b1;
            if (q_valid) begin
               cur_in   = q_entry;
               quot_in  = q_entry.use_recip ? recip_quot : q_entry.magnitude;
               rem_in   = '0;
               step_in  = '0;
               state_in = (q_entry.available && q_entry.use_div && !q_entry.use_recip)
                          ? BACK_DIVIDE : BACK_EVAL;
            end
         end
         BACK_DIVIDE: begin
            rem_in  = trial_ok ? DIV_WIDTH'(trial - {1'b0, cur_ff.divisor})
                               : trial[DIV_WIDTH-1:0];
            quot_in = {quot_ff[MAG_WIDTH-2:0], trial_ok};
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(MAG_WIDTH - 1)) begin
               state_in = BACK_EVAL;
            end
         end
         BACK_EVAL: begin
            if (!cur_ff.last) begin
               if (win) begin
                  best_score_in = score;
               end
               best_pos_in  = new_pos;
               have_best_in = new_have;
               state_in     = BACK_IDLE;
            end else if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = new_have;
               rsp_index_in  = new_have ? INDEX_WIDTH'(new_pos) : '0;
               best_score_in = MINUS_ONE;
               best_pos_in   = '0;
               have_best_in  = 1'b0;
               state_in      = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         best_score_ff <= MINUS_ONE;
         best_pos_ff   <= '0;
         have_best_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_score_ff <= best_score_in;
         best_pos_ff   <= best_pos_in;
         have_best_ff  <= have_best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

FILE: src/policy_scored_worker_select.sv
// ----------------------------------------------------------------------------
// policy_scored_worker_select: picks the best-scoring worker of a sequence
//
//   channel  direction  handshake           carries
//   req_ch   in         valid/ready         one worker record per request
//   rsp_ch   out        valid/ready         found, worker_index on last record
//   csr_*    in/out     APB, pready tied 1  policy register at byte 0
//
// Load, round robin and priority policies are scored straight from the queue;
// available deadline records first run the 40-step bit-serial divider.
// Intake and scoring are split by a two-entry queue, so up to two requests
// are taken while scoring or a stalled result is pending.
// Reset is synchronous; policy comes out of reset as round robin.
// ----------------------------------------------------------------------------
module policy_scored_worker_select
   import pssw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   pssw_req_if.sink                  req_ch,
   pssw_rsp_if.source                rsp_ch,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   pssw_policy_type policy_ff;
   pssw_policy_type policy_in;
   logic            q_full;
   logic            q_push;
   pssw_entry_type  push_entry;
   logic            q_pop;
   logic            q_valid;
   pssw_entry_type  pop_entry;
   logic            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {{(CSR_DATA_WIDTH-2){1'b0}}, policy_ff};

   always_comb begin
      policy_in = policy_ff;
      if (csr_write && !csr_paddr[2]) begin
         policy_in = pssw_policy_type'(csr_pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_ROUND_ROBIN;
      end else begin
         policy_ff <= policy_in;
      end
   end

   pssw_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .policy  (policy_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   pssw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   pssw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (pop_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

FILE: src/pssw_checker.sv
// ----------------------------------------------------------------------------
// pssw_checker: port-level checks for the worker selector
// Watches the result channel and the register port over time.
// ----------------------------------------------------------------------------
module pssw_checker
   import pssw_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_found,
   input logic [INDEX_WIDTH-1:0]    rsp_index,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   input logic                      csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_index))
      else $error("result changed while stalled");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_index == '0)
      else $error("empty selection with nonzero index");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_policy_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]
      |=> csr_prdata == {{(CSR_DATA_WIDTH-2){1'b0}}, $past(csr_pwdata[1:0])})
      else $error("policy readback mismatch");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready dropped");

endmodule

bind policy_scored_worker_select pssw_checker u_pssw_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_found   (rsp_ch.found),
   .rsp_index   (rsp_ch.worker_index),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
